// ===== rtl/utu_pkg.sv =====
package utu_pkg;

   typedef enum logic [1:0] {
      KIND_UNIT = 2'd0,
      KIND_OK   = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   localparam logic [7:0]  LEAD2_MASK = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK = 8'hF0;
   localparam logic [7:0]  LEAD3_CODE = 8'hE0;
   localparam logic [7:0]  LEAD4_MASK = 8'hF8;
   localparam logic [7:0]  LEAD4_CODE = 8'hF0;
   localparam logic [7:0]  CONT_MASK  = 8'hC0;
   localparam logic [7:0]  CONT_CODE  = 8'h80;

   localparam logic [2:0]  SEQ_LEN_2  = 3'd2;
   localparam logic [2:0]  SEQ_LEN_3  = 3'd3;
   localparam logic [2:0]  SEQ_LEN_4  = 3'd4;

   localparam logic [20:0] MIN_CP_2   = 21'h00080;
   localparam logic [20:0] MIN_CP_3   = 21'h00800;
   localparam logic [20:0] MIN_CP_4   = 21'h10000;
   localparam logic [20:0] SURR_LO    = 21'h0D800;
   localparam logic [20:0] SURR_HI    = 21'h0DFFF;
   localparam logic [20:0] MAX_CP     = 21'h10FFFF;
   localparam logic [5:0]  HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]  LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10

   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [1:0]  pending;
      logic [2:0]  seq_len;
      logic [20:0] acc;
      logic        failed;
   } state_type;

   typedef struct packed {
      logic [1:0]  n_units;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        status_en;
      kind_type    status_kind;
   } bundle_type;

endpackage

// ===== rtl/utu_if.sv =====
interface utu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, in_byte, end_of_string, input ready);
   modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface utu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic [1:0]  item_kind;
   logic        last_of_run;

   modport source (output valid, code_unit, item_kind, last_of_run, input ready);
   modport sink   (input valid, code_unit, item_kind, last_of_run, output ready);
endinterface

// ===== rtl/utu_decode.sv =====
module utu_decode (
   input  utu_pkg::state_type  cur,
   input  logic [7:0]          in_byte,
   input  logic                eos,
   output utu_pkg::state_type  nxt,
   output utu_pkg::bundle_type res
);

   logic [20:0] acc_sh;
   logic [1:0]  pend_dec;
   logic        cp_bad;
   logic [20:0] cp_off;

   assign acc_sh   = {cur.acc[14:0], in_byte[5:0]};
   assign pend_dec = cur.pending - 2'd1;
   assign cp_off   = acc_sh - utu_pkg::MIN_CP_4;

   always_comb begin
      nxt             = cur;
      res.n_units     = 2'd0;
      res.unit0       = '0;
      res.unit1       = '0;
      res.status_en   = eos;
      res.status_kind = utu_pkg::KIND_OK;
      cp_bad          = 1'b0;

      if (!cur.failed) begin
         if (cur.pending == 2'd0) begin
            priority if (in_byte[7] == 1'b0) begin
               res.n_units = 2'd1;
               res.unit0   = {8'h00, in_byte};
            end else if ((in_byte & utu_pkg::LEAD2_MASK) == utu_pkg::LEAD2_CODE) begin
               nxt.pending = 2'd1;
               nxt.seq_len = utu_pkg::SEQ_LEN_2;
               nxt.acc     = {16'd0, in_byte[4:0]};
            end else if ((in_byte & utu_pkg::LEAD3_MASK) == utu_pkg::LEAD3_CODE) begin
               nxt.pending = 2'd2;
               nxt.seq_len = utu_pkg::SEQ_LEN_3;
               nxt.acc     = {17'd0, in_byte[3:0]};
            end else if ((in_byte & utu_pkg::LEAD4_MASK) == utu_pkg::LEAD4_CODE) begin
               nxt.pending = 2'd3;
               nxt.seq_len = utu_pkg::SEQ_LEN_4;
               nxt.acc     = {18'd0, in_byte[2:0]};
            end else begin
               nxt.failed = 1'b1;
            end
         end else if ((in_byte & utu_pkg::CONT_MASK) != utu_pkg::CONT_CODE) begin
            nxt.failed = 1'b1;
         end else begin
            nxt.acc     = acc_sh;
            nxt.pending = pend_dec;
            if (pend_dec == 2'd0) begin
               unique case (cur.seq_len)
                  utu_pkg::SEQ_LEN_2: cp_bad = acc_sh < utu_pkg::MIN_CP_2;
                  utu_pkg::SEQ_LEN_3: cp_bad = (acc_sh < utu_pkg::MIN_CP_3) ||
                                               ((acc_sh >= utu_pkg::SURR_LO) &&
                                                (acc_sh <= utu_pkg::SURR_HI));
                  default:            cp_bad = (acc_sh < utu_pkg::MIN_CP_4) ||
                                               (acc_sh > utu_pkg::MAX_CP);
               endcase
               if (cp_bad) begin
                  nxt.failed = 1'b1;
               end else if (acc_sh[20:16] == 5'd0) begin
                  res.n_units = 2'd1;
                  res.unit0   = acc_sh[15:0];
               end else begin
                  // split into a surrogate pair
                  res.n_units = 2'd2;
                  res.unit0   = {utu_pkg::HI_SURR_TAG, cp_off[19:10]};
                  res.unit1   = {utu_pkg::LO_SURR_TAG, cp_off[9:0]};
               end
               nxt.seq_len = '0;
               nxt.acc     = '0;
            end
         end
      end

      if (eos) begin
         res.status_kind = (nxt.failed || (nxt.pending != 2'd0)) ?
                           utu_pkg::KIND_BAD : utu_pkg::KIND_OK;
         nxt = '0;
      end
   end

endmodule

// ===== rtl/utf8_to_utf16_strict_top.sv =====
// Channel  Dir  Payload                                  Accepted when
// req_chan in   in_byte[7:0], end_of_string              valid && ready
// rsp_chan out  code_unit[15:0], item_kind, last_of_run  valid && ready
//
// Each request byte is decoded in the cycle it is accepted; its 0 to 3 results
// land in a three-entry result register and drain one per cycle.
// A byte with at most one result sustains one request per clock; a byte that
// yields a surrogate pair and/or status holds the request side until its last result drains.
// Synchronous reset clears the decode state and empties the result register.
// A stalled rsp_chan holds the result register and the request side with it.
module utf8_to_utf16_strict_top (
   input  logic      clock,
   input  logic      reset,
   utu_req_if.sink   req_chan,
   utu_rsp_if.source rsp_chan
);

   utu_pkg::state_type  state_ff;
   utu_pkg::state_type  state_in;
   utu_pkg::bundle_type res;

   logic [15:0]       ent_unit_ff [utu_pkg::MAX_RESULTS];
   utu_pkg::kind_type ent_kind_ff [utu_pkg::MAX_RESULTS];
   logic [15:0]       ent_unit_in [utu_pkg::MAX_RESULTS];
   utu_pkg::kind_type ent_kind_in [utu_pkg::MAX_RESULTS];
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic [1:0]        idx_ff;

   logic req_fire;
   logic rsp_fire;
   logic last_out;

   utu_decode u_decode (
      .cur     (state_ff),
      .in_byte (req_chan.in_byte),
      .eos     (req_chan.end_of_string),
      .nxt     (state_in),
      .res     (res)
   );

   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign last_out       = idx_ff == (cnt_ff - 2'd1);
   assign req_chan.ready = (cnt_ff == 2'd0) || (rsp_fire && last_out);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = cnt_ff != 2'd0;
   assign rsp_chan.code_unit   = ent_unit_ff[idx_ff];
   assign rsp_chan.item_kind   = ent_kind_ff[idx_ff];
   assign rsp_chan.last_of_run = last_out;

   // pack code units first, status after them
   always_comb begin
      for (int i = 0; i < utu_pkg::MAX_RESULTS; i++) begin
         ent_unit_in[i] = '0;
         ent_kind_in[i] = utu_pkg::KIND_UNIT;
      end
      ent_unit_in[0] = res.unit0;
      ent_unit_in[1] = res.unit1;
      if (res.status_en) begin
         ent_unit_in[res.n_units] = '0;
         ent_kind_in[res.n_units] = res.status_kind;
      end
      cnt_in = res.n_units + {1'b0, res.status_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= '0;
      end else if (rsp_fire) begin
         if (last_out) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < utu_pkg::MAX_RESULTS; i++) begin
            ent_unit_ff[i] <= ent_unit_in[i];
            ent_kind_ff[i] <= ent_kind_in[i];
         end
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (idx_ff < cnt_ff))
      else $error("result index beyond result count");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.item_kind != utu_pkg::KIND_UNIT)) |->
      rsp_chan.last_of_run)
      else $error("status result not last of run");

   a_accept_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ((cnt_ff == 2'd0) || (rsp_fire && last_out)))
      else $error("request accepted over undelivered results");

   a_state_clear_after_eos: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.end_of_string) |=>
      ((state_ff.pending == 2'd0) && (state_ff.seq_len == 3'd0) &&
       (state_ff.acc == 21'd0) && !state_ff.failed))
      else $error("decode state not cleared at end of string");

   a_eos_gives_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.end_of_string) |=>
      ((cnt_ff != 2'd0) && (ent_kind_ff[cnt_ff - 2'd1] != utu_pkg::KIND_UNIT)))
      else $error("end of string produced no status");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 280;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 10;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic [15:0]       code_unit;
      utu_pkg::kind_type kind;
      logic              last;
   } utf16_item_type;

   class utf16_checker;
      logic [1:0]     cont_left;
      logic [2:0]     seq_len;
      logic [20:0]    code_acc;
      logic           str_failed;
      utf16_item_type run_q[$];
      utf16_item_type pending_units[$];
      int             fail_count;

      function new();
         cont_left  = '0;
         seq_len    = '0;
         code_acc   = '0;
         str_failed = 1'b0;
         fail_count = 0;
      endfunction

      function int outstanding();
         return pending_units.size();
      endfunction

      function void push_item(logic [15:0] cu, utu_pkg::kind_type kind);
         utf16_item_type it;
         it.code_unit = cu;
         it.kind      = kind;
         it.last      = 1'b0;
         run_q.insert(run_q.size(), it);
      endfunction

      // Pass BMP points as one unit; split points above the BMP into a high/low surrogate pair.
      function void add_point(logic [20:0] cp);
         logic [19:0] off;
         if (cp <= 21'h00FFFF) begin
            push_item(cp[15:0], utu_pkg::KIND_UNIT);
         end else begin
            off = 20'(cp - 21'h10000);
            push_item(16'hD800 + {6'd0, off[19:10]}, utu_pkg::KIND_UNIT);
            push_item(16'hDC00 + {6'd0, off[9:0]}, utu_pkg::KIND_UNIT);
         end
      endfunction

      function void decode_byte(logic [7:0] c, logic eos);
         logic [20:0] cp;
         logic        bad;
         run_q.delete();
         if (!str_failed) begin
            if (cont_left == 2'd0) begin
               if (c < 8'h80) begin
                  add_point({13'd0, c});
               end else if ((c & utu_pkg::LEAD2_MASK) == utu_pkg::LEAD2_CODE) begin
                  cont_left = 2'd1;
                  seq_len   = utu_pkg::SEQ_LEN_2;
                  code_acc  = {16'd0, c[4:0]};
               end else if ((c & utu_pkg::LEAD3_MASK) == utu_pkg::LEAD3_CODE) begin
                  cont_left = 2'd2;
                  seq_len   = utu_pkg::SEQ_LEN_3;
                  code_acc  = {17'd0, c[3:0]};
               end else if ((c & utu_pkg::LEAD4_MASK) == utu_pkg::LEAD4_CODE) begin
                  cont_left = 2'd3;
                  seq_len   = utu_pkg::SEQ_LEN_4;
                  code_acc  = {18'd0, c[2:0]};
               end else begin
                  str_failed = 1'b1;
               end
            end else if ((c & utu_pkg::CONT_MASK) != utu_pkg::CONT_CODE) begin
               // a bad continuation byte is not reread as a lead
               str_failed = 1'b1;
            end else begin
               code_acc  = {code_acc[14:0], c[5:0]};
               cont_left = cont_left - 2'd1;
               if (cont_left == 2'd0) begin
                  cp = code_acc;
                  case (seq_len)
                     utu_pkg::SEQ_LEN_2: bad = cp < utu_pkg::MIN_CP_2;
                     utu_pkg::SEQ_LEN_3: bad = cp < utu_pkg::MIN_CP_3 ||
                                               (cp >= utu_pkg::SURR_LO &&
                                                cp <= utu_pkg::SURR_HI);
                     default:            bad = cp < utu_pkg::MIN_CP_4 ||
                                               cp > utu_pkg::MAX_CP;
                  endcase
                  if (bad) str_failed = 1'b1;
                  else add_point(cp);
                  seq_len  = '0;
                  code_acc = '0;
               end
            end
         end
         if (eos) begin
            push_item(16'd0, (str_failed || cont_left != 2'd0) ?
                      utu_pkg::KIND_BAD : utu_pkg::KIND_OK);
            cont_left  = '0;
            seq_len    = '0;
            code_acc   = '0;
            str_failed = 1'b0;
         end
         if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
         foreach (run_q[i]) pending_units.insert(pending_units.size(), run_q[i]);
      endfunction

      function void compare_unit(logic [15:0] cu, logic [1:0] kind, logic last);
         utf16_item_type want;
         if (pending_units.size() == 0) begin
            $error("unexpected result: code_unit %h, item_kind %0d, last_of_run %0d",
                   cu, kind, last);
            fail_count++;
            return;
         end
         want = pending_units.pop_front();
         if (want.code_unit !== cu) begin
            $error("code_unit: expected %h, actual %h", want.code_unit, cu);
            fail_count++;
         end
         if (want.kind !== kind) begin
            $error("item_kind: expected %0d, actual %0d", want.kind, kind);
            fail_count++;
         end
         if (want.last !== last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, last);
            fail_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   req_idle_on;
   bit   rsp_stall_on;
   int   bytes_sent;
   int   idle_cycles;

   utu_req_if req_chan ();
   utu_rsp_if rsp_chan ();

   utf8_to_utf16_strict_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utf16_checker board = new();

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.decode_byte(req_chan.in_byte, req_chan.end_of_string);
         if (rsp_chan.valid && rsp_chan.ready)
            board.compare_unit(rsp_chan.code_unit, rsp_chan.item_kind, rsp_chan.last_of_run);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: stall in bursts, then hold ready for a random stretch.
   initial begin
      int gap;
      forever begin
         gap = pick_gap(rsp_stall_on);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.in_byte       <= b;
      req_chan.end_of_string <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_string(input byte_q_type s);
      for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
   endtask

   function automatic void put_utf8(ref byte_q_type s, input logic [20:0] cp);
      if (cp < 21'h80) begin
         s.insert(s.size(), cp[7:0]);
      end else if (cp < 21'h800) begin
         s.insert(s.size(), {3'b110, cp[10:6]});
         s.insert(s.size(), {2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         s.insert(s.size(), {4'b1110, cp[15:12]});
         s.insert(s.size(), {2'b10, cp[11:6]});
         s.insert(s.size(), {2'b10, cp[5:0]});
      end else begin
         s.insert(s.size(), {5'b11110, cp[20:18]});
         s.insert(s.size(), {2'b10, cp[17:12]});
         s.insert(s.size(), {2'b10, cp[11:6]});
         s.insert(s.size(), {2'b10, cp[5:0]});
      end
   endfunction

   function automatic logic [20:0] random_point();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 8))
            0: return 21'h00007F;
            1: return 21'h000080;
            2: return 21'h0007FF;
            3: return 21'h000800;
            4: return 21'h00D7FF;
            5: return 21'h00E000;
            6: return 21'h00FFFF;
            7: return 21'h010000;
            default: return 21'h10FFFF;
         endcase
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 21'($urandom_range(0, 'h7F));
         4, 5:       return 21'($urandom_range('h80, 'h7FF));
         6, 7:       return 21'($urandom_range('h800, 'hFFFF));
         default:    return 21'($urandom_range('h10000, 'h10FFFF));
      endcase
   endfunction

   // Mostly well-formed strings; a share of them damaged or pure noise.
   task automatic build_string(output byte_q_type s);
      int          r;
      int          pos;
      logic [7:0]  ch;
      s = {};
      r = $urandom_range(0, 99);
      if (r >= 95) begin
         repeat ($urandom_range(1, 5)) s.insert(s.size(), 8'($urandom));
         return;
      end
      repeat ($urandom_range(1, 5)) put_utf8(s, random_point());
      if (r >= 90) begin
         // overlong two-byte form of an ASCII character
         ch = 8'($urandom_range(0, 'h7F));
         s.insert(s.size(), {6'b110000, ch[7:6]});
         s.insert(s.size(), {2'b10, ch[5:0]});
      end else if (r >= 84) begin
         pos = $urandom_range(0, s.size());
         s.insert(pos, 8'($urandom));
      end else if (r >= 78) begin
         if (s.size() > 1) s.delete(s.size() - 1);
      end else if (r >= 70) begin
         pos = $urandom_range(0, s.size() - 1);
         s[pos] = 8'($urandom);
      end
   endtask

   initial begin
      byte_q_type s;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.in_byte       <= 8'h00;
      req_chan.end_of_string <= 1'b0;
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      bytes_sent   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_string('{8'h00});
      send_string('{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
      send_string('{8'hC0, 8'h80});
      send_string('{8'hED, 8'hA0, 8'h80});
      send_string('{8'hF5, 8'h80, 8'h80, 8'h80});
      send_string('{8'h41, 8'hE2, 8'h41});
      send_string('{8'hE2, 8'h82});
      send_string('{8'hFF, 8'h41});

      while (bytes_sent < ITEM_TARGET) begin
         req_idle_on  = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         build_string(s);
         send_string(s);
      end

      req_chan.valid <= 1'b0;
      rsp_stall_on = 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.fail_count == 0 && board.outstanding() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
